[rtl/core/frwl_pkg.sv]
// ----------------------------------------------------------------------------
// frwl_pkg
// Types and codes shared by the reader-writer lock manager.
// ----------------------------------------------------------------------------
package frwl_pkg;

    localparam logic [3:0] REQ_TRY_WRITE    = 4'd0;
    localparam logic [3:0] REQ_WRITE        = 4'd1;
    localparam logic [3:0] REQ_TRY_READ     = 4'd2;
    localparam logic [3:0] REQ_READ         = 4'd3;
    localparam logic [3:0] REQ_WRITE_UNLOCK = 4'd4;
    localparam logic [3:0] REQ_READ_UNLOCK  = 4'd5;
    localparam logic [3:0] REQ_SLEEP        = 4'd6;
    localparam logic [3:0] REQ_WAKE         = 4'd7;
    localparam logic [3:0] REQ_WAKE_ALL     = 4'd8;

    localparam logic [3:0] EV_GRANTED  = 4'd0;
    localparam logic [3:0] EV_REFUSED  = 4'd1;
    localparam logic [3:0] EV_QUEUED   = 4'd2;
    localparam logic [3:0] EV_WOKEN    = 4'd3;
    localparam logic [3:0] EV_MOVED    = 4'd4;
    localparam logic [3:0] EV_NONE     = 4'd5;
    localparam logic [3:0] EV_SLEEPING = 4'd6;
    localparam logic [3:0] EV_OVERFLOW = 4'd7;
    localparam logic [3:0] EV_MISUSE   = 4'd8;

    typedef struct packed {
        logic [3:0] req_type;
        logic [7:0] thread_id;
    } req_t;

    typedef struct packed {
        logic [3:0] event_res;
        logic [7:0] event_thread;
        logic       write_mode;
        logic       last;
    } res_t;

endpackage

[rtl/core/frwl_front.sv]
// ----------------------------------------------------------------------------
// frwl_front
// Accepts requests and holds them in a short queue for the lock engine.
// ----------------------------------------------------------------------------
module frwl_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  frwl_pkg::req_t  in_data,
    output logic            q_valid,
    input  logic            q_ready,
    output frwl_pkg::req_t  q_data
);
    import frwl_pkg::*;

    req_t       slot_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic       push;
    logic       pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_data   = slot_reg[rptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= ~wptr_reg;
            end
            if (pop)
            begin
                rptr_reg <= ~rptr_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

[rtl/core/frwl_back.sv]
// ----------------------------------------------------------------------------
// frwl_back
// Lock engine: carries out one request at a time, taking the next only when idle.
// ----------------------------------------------------------------------------
module frwl_back
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int WAIT_DEPTH  = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    output logic            q_ready,
    input  frwl_pkg::req_t  q_data,
    output logic            out_valid,
    input  logic            out_ready,
    output frwl_pkg::res_t  out_data
);
    import frwl_pkg::*;

    localparam int QW  = $clog2(QUEUE_DEPTH);
    localparam int WW  = $clog2(WAIT_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam int WCW = $clog2(WAIT_DEPTH + 1);
    localparam logic [QCW-1:0] QFULL = QCW'(QUEUE_DEPTH);
    localparam logic [WCW-1:0] WFULL = WCW'(WAIT_DEPTH);
    localparam logic [QW-1:0]  QLAST = QW'(QUEUE_DEPTH - 1);
    localparam logic [WW-1:0]  WLAST = WW'(WAIT_DEPTH - 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_RDQ   = 3'd1;
    localparam logic [2:0] ST_REL   = 3'd2;
    localparam logic [2:0] ST_POST  = 3'd3;
    localparam logic [2:0] ST_RDW   = 3'd4;
    localparam logic [2:0] ST_WAKE  = 3'd5;

    logic [7:0]     qid_mem [QUEUE_DEPTH];
    logic           qmd_mem [QUEUE_DEPTH];
    logic [7:0]     wid_mem [WAIT_DEPTH];

    logic [2:0]     state_reg, state_next;
    req_t           req_reg, req_next;
    logic           wh_reg, wh_next;
    logic [7:0]     rc_reg, rc_next;
    logic [QW-1:0]  qh_reg, qh_next;
    logic [QCW-1:0] qc_reg, qc_next;
    logic [WW-1:0]  wh2_reg, wh2_next;
    logic [WCW-1:0] wc_reg, wc_next;
    res_t           o_reg, o_next;
    logic           ov_reg, ov_next;
    logic           can_emit;
    logic [7:0]     rd_id_reg;
    logic           rd_md_reg;
    logic           rd_md2_reg;
    logic [7:0]     rd_wid_reg;
    logic [QW-1:0]  qh_inc;
    logic [QW-1:0]  qh_dec;
    logic [QW:0]    q_sum;
    logic [QW-1:0]  q_tail;
    logic [WW-1:0]  wh2_inc;
    logic [WW:0]    w_sum;
    logic [WW-1:0]  w_tail;
    logic           run_more;
    logic           qwe;
    logic [QW-1:0]  qwa;
    logic [7:0]     qwid;
    logic           qwmd;
    logic           wwe;

    assign out_valid = ov_reg;
    assign out_data  = o_reg;
    assign can_emit  = !ov_reg || out_ready;
    assign q_ready   = (state_reg == ST_IDLE) && can_emit;

    assign qh_inc  = (qh_reg == QLAST) ? '0 : qh_reg + QW'(1);
    assign qh_dec  = (qh_reg == '0) ? QLAST : qh_reg - QW'(1);
    assign q_sum   = {1'b0, qh_reg} + (QW+1)'(qc_reg);
    assign q_tail  = (q_sum >= (QW+1)'(QUEUE_DEPTH))
                     ? QW'(q_sum - (QW+1)'(QUEUE_DEPTH)) : q_sum[QW-1:0];
    assign wh2_inc = (wh2_reg == WLAST) ? '0 : wh2_reg + WW'(1);
    assign w_sum   = {1'b0, wh2_reg} + (WW+1)'(wc_reg);
    assign w_tail  = (w_sum >= (WW+1)'(WAIT_DEPTH))
                     ? WW'(w_sum - (WW+1)'(WAIT_DEPTH)) : w_sum[WW-1:0];

    // another reader follows the one at the queue front
    assign run_more = (qc_reg > QCW'(1)) && !rd_md2_reg;

    always_ff @(posedge clk)
    begin
        if (qwe)
        begin
            qid_mem[qwa] <= qwid;
            qmd_mem[qwa] <= qwmd;
        end
        if (wwe)
        begin
            wid_mem[w_tail] <= req_reg.thread_id;
        end
        rd_id_reg  <= qid_mem[qh_reg];
        rd_md_reg  <= qmd_mem[qh_reg];
        rd_md2_reg <= qmd_mem[qh_inc];
        rd_wid_reg <= wid_mem[wh2_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        req_next   = req_reg;
        wh_next    = wh_reg;
        rc_next    = rc_reg;
        qh_next    = qh_reg;
        qc_next    = qc_reg;
        wh2_next   = wh2_reg;
        wc_next    = wc_reg;
        o_next     = o_reg;
        ov_next    = ov_reg && !out_ready;
        qwe        = 1'b0;
        qwa        = q_tail;
        qwid       = q_data.thread_id;
        qwmd       = 1'b0;
        wwe        = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid && can_emit)
                begin
                    req_next            = q_data;
                    o_next.event_thread = q_data.thread_id;
                    o_next.write_mode   = 1'b0;
                    o_next.last         = 1'b1;
                    o_next.event_res    = EV_MISUSE;
                    ov_next             = 1'b1;
                    case (q_data.req_type)
                        REQ_TRY_WRITE, REQ_WRITE:
                        begin
                            o_next.write_mode = 1'b1;
                            if (!wh_reg && rc_reg == 8'd0)
                            begin
                                wh_next = 1'b1;
                                o_next.event_res = EV_GRANTED;
                            end
                            else if (q_data.req_type == REQ_TRY_WRITE)
                            begin
                                o_next.event_res = EV_REFUSED;
                            end
                            else if (qc_reg < QFULL)
                            begin
                                qwe = 1'b1;
                                qwmd = 1'b1;
                                qc_next = qc_reg + QCW'(1);
                                o_next.event_res = EV_QUEUED;
                            end
                            else
                            begin
                                o_next.write_mode = 1'b0;
                                o_next.event_res = EV_OVERFLOW;
                            end
                        end
                        REQ_TRY_READ, REQ_READ:
                        begin
                            if (!wh_reg && qc_reg == '0)
                            begin
                                if (rc_reg == 8'd255)
                                begin
                                    o_next.event_res = EV_OVERFLOW;
                                end
                                else
                                begin
                                    rc_next = rc_reg + 8'd1;
                                    o_next.event_res = EV_GRANTED;
                                end
                            end
                            else if (q_data.req_type == REQ_TRY_READ)
                            begin
                                o_next.event_res = EV_REFUSED;
                            end
                            else if (qc_reg < QFULL)
                            begin
                                qwe = 1'b1;
                                qc_next = qc_reg + QCW'(1);
                                o_next.event_res = EV_QUEUED;
                            end
                            else
                            begin
                                o_next.event_res = EV_OVERFLOW;
                            end
                        end
                        REQ_WRITE_UNLOCK:
                        begin
                            if (wh_reg && rc_reg == 8'd0)
                            begin
                                ov_next = 1'b0;
                                state_next = ST_RDQ;
                            end
                        end
                        REQ_READ_UNLOCK:
                        begin
                            if (!wh_reg && rc_reg != 8'd0)
                            begin
                                rc_next = rc_reg - 8'd1;
                                if (rc_reg == 8'd1)
                                begin
                                    ov_next = 1'b0;
                                    state_next = ST_RDQ;
                                end
                                else
                                begin
                                    o_next.event_res = EV_NONE;
                                end
                            end
                        end
                        REQ_SLEEP:
                        begin
                            if (wh_reg && rc_reg == 8'd0)
                            begin
                                if (wc_reg >= WFULL)
                                begin
                                    o_next.event_res = EV_OVERFLOW;
                                end
                                else
                                begin
                                    ov_next = 1'b0;
                                    state_next = ST_RDQ;
                                end
                            end
                        end
                        REQ_WAKE, REQ_WAKE_ALL:
                        begin
                            if (wh_reg)
                            begin
                                ov_next = 1'b0;
                                state_next = ST_RDW;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RDQ:
            begin
                state_next = ST_REL;
            end
            ST_REL:
            begin
                if (can_emit)
                begin
                    ov_next             = 1'b1;
                    o_next.event_res    = EV_WOKEN;
                    o_next.event_thread = rd_id_reg;
                    o_next.write_mode   = 1'b0;
                    o_next.last         = (req_reg.req_type != REQ_SLEEP);
                    state_next = (req_reg.req_type == REQ_SLEEP) ? ST_POST : ST_IDLE;
                    if (qc_reg == '0)
                    begin
                        wh_next = 1'b0;
                        if (req_reg.req_type == REQ_SLEEP)
                        begin
                            ov_next = 1'b0;
                        end
                        else
                        begin
                            o_next.event_res    = EV_NONE;
                            o_next.event_thread = req_reg.thread_id;
                        end
                    end
                    else
                    begin
                        qh_next = qh_inc;
                        qc_next = qc_reg - QCW'(1);
                        if (rd_md_reg)
                        begin
                            wh_next = 1'b1;
                            o_next.write_mode = 1'b1;
                        end
                        else
                        begin
                            wh_next = 1'b0;
                            if (rc_reg != 8'd255)
                            begin
                                rc_next = rc_reg + 8'd1;
                            end
                            if (run_more)
                            begin
                                o_next.last = 1'b0;
                                state_next  = ST_RDQ;
                            end
                        end
                    end
                end
            end
            ST_POST:
            begin
                if (can_emit)
                begin
                    wwe     = 1'b1;
                    wc_next = wc_reg + WCW'(1);
                    o_next.event_res    = EV_SLEEPING;
                    o_next.event_thread = req_reg.thread_id;
                    o_next.write_mode   = 1'b0;
                    o_next.last         = 1'b1;
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RDW:
            begin
                state_next = ST_WAKE;
            end
            ST_WAKE:
            begin
                if (can_emit)
                begin
                    ov_next             = 1'b1;
                    o_next.event_thread = req_reg.thread_id;
                    o_next.write_mode   = 1'b0;
                    o_next.last         = 1'b1;
                    state_next          = ST_IDLE;
                    if (wc_reg == '0)
                    begin
                        o_next.event_res = EV_NONE;
                    end
                    else if (qc_reg >= QFULL)
                    begin
                        o_next.event_res = EV_OVERFLOW;
                    end
                    else
                    begin
                        wh2_next = wh2_inc;
                        wc_next  = wc_reg - WCW'(1);
                        qh_next  = qh_dec;
                        qwe      = 1'b1;
                        qwa      = qh_dec;
                        qwid     = rd_wid_reg;
                        qwmd     = 1'b1;
                        qc_next  = qc_reg + QCW'(1);
                        o_next.event_res    = EV_MOVED;
                        o_next.event_thread = rd_wid_reg;
                        o_next.write_mode   = 1'b1;
                        if (req_reg.req_type == REQ_WAKE_ALL && wc_reg != WCW'(1))
                        begin
                            o_next.last = 1'b0;
                            state_next  = ST_RDW;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        o_reg <= o_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            req_reg   <= '0;
            wh_reg    <= 1'b0;
            rc_reg    <= 8'd0;
            qh_reg    <= '0;
            qc_reg    <= '0;
            wh2_reg   <= '0;
            wc_reg    <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            req_reg   <= req_next;
            wh_reg    <= wh_next;
            rc_reg    <= rc_next;
            qh_reg    <= qh_next;
            qc_reg    <= qc_next;
            wh2_reg   <= wh2_next;
            wc_reg    <= wc_next;
            ov_reg    <= ov_next;
        end
    end

endmodule

[rtl/core/fifo_reader_writer_lock_with_condition.sv]
// ----------------------------------------------------------------------------
// fifo_reader_writer_lock_with_condition
// Fair reader-writer lock with condition variable, thread-tagged requests.
//
//   channel | handshake           | payload
//   in      | in_valid/in_ready   | req_t (req_type, thread_id)
//   out     | out_valid/out_ready | res_t (event_res, event_thread, write_mode, last)
//
// a lock, try-lock or misuse request is handled in the idle state.
// a release runs RDQ, REL per woken thread (once if none woken); sleep adds POST.
// a wake: RDW, WAKE per moved thread, plus once for an overflow or none_waiting end.
// reset clears lock state and all pointers; no clearing pass.
// a stalled output holds the engine; the two-entry request queue then fills.
// ----------------------------------------------------------------------------
module fifo_reader_writer_lock_with_condition
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int WAIT_DEPTH  = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  frwl_pkg::req_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output frwl_pkg::res_t  out_data
);
    import frwl_pkg::*;

    logic q_valid;
    logic q_ready;
    req_t q_data;

    frwl_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_data   (q_data)
    );

    frwl_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .WAIT_DEPTH(WAIT_DEPTH)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[rtl/core/frwl_checker.sv]
// ----------------------------------------------------------------------------
// frwl_checker
// Port-level checks of the lock manager.
// ----------------------------------------------------------------------------
module frwl_checker
(
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input frwl_pkg::req_t  in_data,
    input logic            out_valid,
    input logic            out_ready,
    input frwl_pkg::res_t  out_data
);
    import frwl_pkg::*;

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_data))
        else $error("input changed while waiting");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.event_res <= EV_MISUSE)
        else $error("bad event code");

    a_wm_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.write_mode |->
            (out_data.event_res == EV_GRANTED || out_data.event_res == EV_REFUSED ||
             out_data.event_res == EV_QUEUED || out_data.event_res == EV_WOKEN ||
             out_data.event_res == EV_MOVED))
        else $error("write mode on wrong event");

    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("output valid in reset");

endmodule

bind fifo_reader_writer_lock_with_condition frwl_checker u_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

[sim/fifo_reader_writer_lock_with_condition_tb.sv]
// ----------------------------------------------------------------------------
// fifo_reader_writer_lock_with_condition_tb
// Self-checking bench for the reader-writer lock manager: a lock-state
// predictor tracks writer, readers, lock queue and wait list, and every
// output transaction is checked field by field against the expected events.
// ----------------------------------------------------------------------------
module fifo_reader_writer_lock_with_condition_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import frwl_pkg::*;

    localparam int QDEPTH = 16;
    localparam int WDEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_EVENTS = QDEPTH + 1;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    req_t in_data;
    logic out_valid;
    logic out_ready;
    res_t out_data;

    fifo_reader_writer_lock_with_condition #(
        .QUEUE_DEPTH (QDEPTH),
        .WAIT_DEPTH  (WDEPTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // lock state mirror
    logic       writer_held;
    logic [7:0] writer_owner;
    logic [7:0] reader_count;
    logic [7:0] lq_ids [QDEPTH];
    logic       lq_mode [QDEPTH];
    logic [3:0] lq_head;
    int         lq_count;
    logic [7:0] wl_ids [WDEPTH];
    logic [3:0] wl_head;
    int         wl_count;

    res_t expected_events[$];
    int   error_count;
    int   event_count;
    int   request_count;
    int   cycle_count;
    bit   hold_off;
    int   hold_left;
    int   max_readers;
    int   max_wake_run;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("timeout after %0d cycles", cycle_count);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string what);
        error_count++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    function automatic void push_event(input logic [3:0] res, input logic [7:0] th,
                                       input logic wm);
        res_t e;
        e.event_res = res;
        e.event_thread = th;
        e.write_mode = wm;
        e.last = 1'b0;
        expected_events.push_back(e);
    endfunction

    function automatic logic [7:0] lq_pop();
        logic [7:0] id;
        id = lq_ids[lq_head];
        lq_head = lq_head + 4'd1;
        lq_count--;
        return id;
    endfunction

    function automatic int hand_on_lock();
        int n;
        logic [7:0] id;
        n = 0;
        if (lq_count == 0)
        begin
            writer_held = 1'b0;
            return 0;
        end
        if (lq_mode[lq_head])
        begin
            id = lq_pop();
            writer_held = 1'b1;
            writer_owner = id;
            push_event(EV_WOKEN, id, 1'b1);
            return 1;
        end
        writer_held = 1'b0;
        while (lq_count > 0 && !lq_mode[lq_head])
        begin
            id = lq_pop();
            if (reader_count != 8'd255)
                reader_count++;
            push_event(EV_WOKEN, id, 1'b0);
            n++;
        end
        if (n > max_wake_run)
            max_wake_run = n;
        return n;
    endfunction

    function automatic int predict_request(input req_t r);
        int n;
        int base;
        logic [3:0] idx;
        logic [7:0] tid;
        base = expected_events.size();
        tid = r.thread_id;
        n = 0;
        case (r.req_type)
            REQ_TRY_WRITE, REQ_WRITE:
                if (!writer_held && reader_count == 0)
                begin
                    writer_held = 1'b1;
                    writer_owner = tid;
                    push_event(EV_GRANTED, tid, 1'b1);
                end
                else if (r.req_type == REQ_TRY_WRITE)
                    push_event(EV_REFUSED, tid, 1'b1);
                else if (lq_count < QDEPTH)
                begin
                    idx = lq_head + lq_count[3:0];
                    lq_ids[idx] = tid;
                    lq_mode[idx] = 1'b1;
                    lq_count++;
                    push_event(EV_QUEUED, tid, 1'b1);
                end
                else
                    push_event(EV_OVERFLOW, tid, 1'b0);
            REQ_TRY_READ, REQ_READ:
                if (!writer_held && lq_count == 0)
                begin
                    if (reader_count == 8'd255)
                        push_event(EV_OVERFLOW, tid, 1'b0);
                    else
                    begin
                        reader_count++;
                        push_event(EV_GRANTED, tid, 1'b0);
                    end
                end
                else if (r.req_type == REQ_TRY_READ)
                    push_event(EV_REFUSED, tid, 1'b0);
                else if (lq_count < QDEPTH)
                begin
                    idx = lq_head + lq_count[3:0];
                    lq_ids[idx] = tid;
                    lq_mode[idx] = 1'b0;
                    lq_count++;
                    push_event(EV_QUEUED, tid, 1'b0);
                end
                else
                    push_event(EV_OVERFLOW, tid, 1'b0);
            REQ_WRITE_UNLOCK:
                if (!writer_held || reader_count != 0)
                    push_event(EV_MISUSE, tid, 1'b0);
                else if (hand_on_lock() == 0)
                    push_event(EV_NONE, tid, 1'b0);
            REQ_READ_UNLOCK:
                if (writer_held || reader_count == 0)
                    push_event(EV_MISUSE, tid, 1'b0);
                else
                begin
                    reader_count--;
                    if (reader_count == 0)
                        n = hand_on_lock();
                    if (n == 0)
                        push_event(EV_NONE, tid, 1'b0);
                end
            REQ_SLEEP:
                if (!writer_held || reader_count != 0)
                    push_event(EV_MISUSE, tid, 1'b0);
                else if (wl_count >= WDEPTH)
                    push_event(EV_OVERFLOW, tid, 1'b0);
                else
                begin
                    n = hand_on_lock();
                    idx = wl_head + wl_count[3:0];
                    wl_ids[idx] = tid;
                    wl_count++;
                    push_event(EV_SLEEPING, tid, 1'b0);
                end
            REQ_WAKE, REQ_WAKE_ALL:
                if (!writer_held)
                    push_event(EV_MISUSE, tid, 1'b0);
                else
                    forever
                    begin
                        if (wl_count == 0)
                        begin
                            if (n == 0)
                                push_event(EV_NONE, tid, 1'b0);
                            break;
                        end
                        if (lq_count >= QDEPTH)
                        begin
                            push_event(EV_OVERFLOW, tid, 1'b0);
                            break;
                        end
                        lq_head = lq_head - 4'd1;
                        lq_ids[lq_head] = wl_ids[wl_head];
                        lq_mode[lq_head] = 1'b1;
                        lq_count++;
                        push_event(EV_MOVED, wl_ids[wl_head], 1'b1);
                        wl_head = wl_head + 4'd1;
                        wl_count--;
                        n++;
                        if (r.req_type == REQ_WAKE)
                            break;
                    end
            default:
                push_event(EV_MISUSE, tid, 1'b0);
        endcase
        expected_events[expected_events.size() - 1].last = 1'b1;
        if (reader_count > max_readers)
            max_readers = reader_count;
        return expected_events.size() - base;
    endfunction

    task automatic send_request(input logic [3:0] kind, input logic [7:0] tid);
        req_t r;
        int gap;
        int n;
        r.req_type = kind;
        r.thread_id = tid;
        if ($urandom_range(0, 3) == 0)
        begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                              : $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= r;
        do
            @(posedge clk);
        while (!in_ready);
        n = predict_request(r);
        if (n > MAX_EVENTS)
            report_mismatch("predictor produced too many events");
        request_count++;
    endtask

    // output side: random stalls plus a long hold-off counted here
    initial
    begin
        out_ready = 1'b0;
        hold_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                hold_off = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 2) == 0)
                out_ready <= ($urandom_range(0, 19) == 0) ? 1'b0 : 1'($urandom_range(0, 1));
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            event_count++;
            if (expected_events.size() == 0)
                report_mismatch($sformatf("unexpected transaction res=%0d thread=%0d",
                                          out_data.event_res, out_data.event_thread));
            else
            begin
                if (out_data.event_res !== expected_events[0].event_res)
                    report_mismatch($sformatf("event_res got %0d want %0d",
                        out_data.event_res, expected_events[0].event_res));
                if (out_data.event_thread !== expected_events[0].event_thread)
                    report_mismatch($sformatf("event_thread got %0d want %0d",
                        out_data.event_thread, expected_events[0].event_thread));
                if (out_data.write_mode !== expected_events[0].write_mode)
                    report_mismatch($sformatf("write_mode got %0b want %0b",
                        out_data.write_mode, expected_events[0].write_mode));
                if (out_data.last !== expected_events[0].last)
                    report_mismatch($sformatf("last got %0b want %0b",
                        out_data.last, expected_events[0].last));
                void'(expected_events.pop_front());
            end
        end
    end

    task automatic drain_events();
        in_valid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic test_directed();
        send_request(REQ_READ_UNLOCK, 8'd0);
        send_request(REQ_WRITE_UNLOCK, 8'd255);
        send_request(REQ_SLEEP, 8'd1);
        send_request(REQ_WAKE, 8'd2);
        send_request(REQ_WAKE_ALL, 8'd3);
        send_request(4'd9, 8'hAA);
        send_request(4'd15, 8'h55);
        send_request(REQ_TRY_WRITE, 8'd255);
        send_request(REQ_TRY_WRITE, 8'd4);
        send_request(REQ_TRY_READ, 8'd5);
        send_request(REQ_READ, 8'd6);
        send_request(REQ_READ, 8'd7);
        send_request(REQ_WRITE, 8'd8);
        send_request(REQ_READ, 8'd9);
        send_request(REQ_WAKE, 8'd10);
        send_request(REQ_WRITE_UNLOCK, 8'd11);
        send_request(REQ_READ_UNLOCK, 8'd6);
        send_request(REQ_READ_UNLOCK, 8'd7);
        send_request(REQ_SLEEP, 8'd8);
        send_request(REQ_WAKE, 8'd9);
        send_request(REQ_READ_UNLOCK, 8'd9);
        send_request(REQ_WRITE_UNLOCK, 8'd12);
        send_request(REQ_WRITE_UNLOCK, 8'd13);
        drain_events();
    endtask

    // fill the wait list and lock queue, long output hold-off meanwhile
    task automatic test_full_queues();
        int i;
        hold_off = 1'b1;
        send_request(REQ_WRITE, 8'd100);
        for (i = 0; i < WDEPTH + 1; i++)
        begin
            send_request(REQ_SLEEP, 8'(120 + i));
            send_request(REQ_WRITE, 8'(140 + i));
        end
        for (i = 0; i < QDEPTH + 2; i++)
            send_request(REQ_WRITE, 8'(160 + i));
        send_request(REQ_WAKE, 8'd1);
        send_request(REQ_WAKE_ALL, 8'd2);
        while (writer_held || reader_count != 0 || lq_count != 0)
        begin
            if (writer_held)
                send_request((wl_count < WDEPTH && $urandom_range(0, 3) == 0)
                             ? REQ_SLEEP : REQ_WRITE_UNLOCK, 8'($urandom));
            else
                send_request(REQ_READ_UNLOCK, 8'($urandom));
        end
        send_request(REQ_WRITE, 8'd3);
        send_request(REQ_WAKE_ALL, 8'd4);
        while (writer_held)
            send_request(REQ_WRITE_UNLOCK, 8'($urandom));
        drain_events();
    endtask

    // long reader runs, readers queued behind a writer
    task automatic test_reader_runs();
        int i;
        send_request(REQ_WRITE, 8'd50);
        for (i = 0; i < QDEPTH; i++)
            send_request(REQ_READ, 8'(i));
        send_request(REQ_WRITE_UNLOCK, 8'd51);
        send_request(REQ_WRITE, 8'd79);
        send_request(REQ_READ, 8'd77);
        send_request(REQ_TRY_READ, 8'd78);
        send_request(REQ_TRY_WRITE, 8'd80);
        while (reader_count != 0 || lq_count != 0 || writer_held)
            send_request(writer_held ? REQ_WRITE_UNLOCK : REQ_READ_UNLOCK, 8'($urandom));
        drain_events();
    endtask

    task automatic test_random(input int count);
        int i;
        int pick;
        logic [3:0] kind;
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                kind = 4'($urandom_range(9, 15));
            else if (pick < 14)
                kind = 4'($urandom_range(0, 8));
            else if (writer_held)
                kind = (pick < 40) ? REQ_WRITE_UNLOCK : (pick < 55) ? REQ_SLEEP :
                       (pick < 65) ? REQ_WAKE : (pick < 72) ? REQ_WAKE_ALL :
                       (pick < 86) ? REQ_READ : REQ_WRITE;
            else if (reader_count != 0)
                kind = (pick < 50) ? REQ_READ_UNLOCK : (pick < 70) ? REQ_READ :
                       (pick < 80) ? REQ_TRY_READ : REQ_WRITE;
            else
                kind = (pick < 50) ? REQ_WRITE : (pick < 75) ? REQ_READ :
                       (pick < 88) ? REQ_TRY_WRITE : REQ_TRY_READ;
            send_request(kind, 8'($urandom));
        end
        drain_events();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        hold_off = 1'b0;
        error_count = 0;
        event_count = 0;
        request_count = 0;
        max_readers = 0;
        max_wake_run = 0;
        writer_held = 1'b0;
        writer_owner = '0;
        reader_count = '0;
        lq_head = '0;
        lq_count = 0;
        wl_head = '0;
        wl_count = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_full_queues();
        test_reader_runs();
        test_random(230);
        $display("%0d requests, %0d events checked; peak readers %0d, longest wake run %0d",
                 request_count, event_count, max_readers, max_wake_run);
        $display("covered misuse, lock queue and wait list overflow, reader runs, wake paths");
        if (error_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

[sim.f]
rtl/core/frwl_pkg.sv
rtl/core/frwl_front.sv
rtl/core/frwl_back.sv
rtl/core/fifo_reader_writer_lock_with_condition.sv
rtl/core/frwl_checker.sv
sim/fifo_reader_writer_lock_with_condition_tb.sv
